>>> design/fbcs_pkg.sv
// Types and codes shared by the four-bit step unit: the input and result words,
// the program row layout, the flag set, the opcode and function codes and the sequencer states.
// Depends on nothing.
package fbcs_pkg;

    // Function code of an input word
    typedef enum logic [1:0] {
        FUNC_STEP    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_SPARE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_LDA_IMM = 4'd0,
        OP_LDA_MEM = 4'd1,
        OP_LDB_IMM = 4'd2,
        OP_LDB_MEM = 4'd3,
        OP_MUL     = 4'd4,
        OP_DIV     = 4'd5,
        OP_ADD     = 4'd6,
        OP_SUB     = 4'd7,
        OP_STX     = 4'd8,
        OP_STA     = 4'd9,
        OP_STB     = 4'd10,
        OP_JMP     = 4'd11,
        OP_JZE     = 4'd12,
        OP_JOV     = 4'd13,
        OP_JNE     = 4'd14,
        OP_NOP     = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } t_state;

    localparam logic [3:0] PC_RESTART = 4'hF;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] row;
        logic [3:0] opcode;
        logic [3:0] addr;
        logic [3:0] imm;
    } t_in_word;

    typedef struct packed {
        logic [3:0] row_done;
        logic [3:0] acc_a;
        logic [3:0] acc_b;
        logic [3:0] result_x;
        logic       zero_flag;
        logic       negative_flag;
        logic       overflow_flag;
    } t_out_word;

    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] addr;
        logic [3:0] imm;
    } t_prog_row;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic zero;
    } t_flags;

endpackage

>>> design/four_bit_cpu_step_unit.sv
// Four-bit processor step unit: program store and data RAM as synchronous memories,
// a small sequencer that fetches, executes and writes back one program row per step word.
// Depends on fbcs_pkg.
//
//  channel  valid        stall        payload      direction
//  input    i_in_valid   o_in_stall   i_in_data    into the unit
//  result   o_out_valid  i_out_stall  o_out_data   out of the unit
//
// A row write, a restart or a spare word gives its result in the cycle after acceptance.
// A step reads the program store, then executes; RAM loads then wait for the
// data RAM read. The registered reads of the two memories set this order.
// Reset sets the row counter to 15 and clears registers, flags and the memory valid bits.
// A stalled result blocks new words until it is taken.
module four_bit_cpu_step_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fbcs_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fbcs_pkg::t_out_word o_out_data
);
    import fbcs_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_pc, n_pc;
    logic [3:0] r_a, n_a;
    logic [3:0] r_b, n_b;
    logic [3:0] r_x, n_x;
    t_flags     r_flags, n_flags;

    t_prog_row  prog_mem [16];
    logic [15:0] r_prog_vld;
    t_prog_row  r_prog_q;
    logic       r_prog_q_vld;
    t_prog_row  row_w;
    logic [3:0] prog_ra;
    logic       prog_we;

    logic [3:0] ram_mem [16];
    logic [15:0] r_ram_vld;
    logic [3:0] r_ram_q;
    logic       r_ram_q_vld;
    logic [3:0] ram_rd;
    logic       ram_we;
    logic [3:0] ram_wd;
    logic       ram_clear;

    logic       r_load_b;
    logic       accept;
    logic       done;
    t_out_word  r_out;
    logic       r_out_valid;

    logic [7:0] mul_p;
    logic [4:0] add_s;
    logic [4:0] sub_d;
    logic [3:0] div_q;

    function automatic logic [3:0] div4(input logic [3:0] num, input logic [3:0] den);
        logic [4:0] rem;
        logic [3:0] q;
        rem = '0;
        q   = '0;
        for (int i = 3; i >= 0; i--) begin
            rem = {rem[3:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    assign accept  = i_in_valid && !o_in_stall;
    assign prog_ra = r_pc + 4'd1;
    assign row_w   = r_prog_q_vld ? r_prog_q : '0;
    assign ram_rd  = r_ram_q_vld ? r_ram_q : '0;

    assign mul_p = r_a * r_b;
    assign add_s = {1'b0, r_a} + {1'b0, r_b};
    assign sub_d = {1'b0, r_a} - {1'b0, r_b};
    assign div_q = div4(r_a, r_b);

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            prog_mem[i_in_data.row] <= t_prog_row'({i_in_data.opcode, i_in_data.addr,
                                                    i_in_data.imm});
        end
        r_prog_q     <= prog_mem[prog_ra];
        r_prog_q_vld <= r_prog_vld[prog_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            ram_mem[row_w.addr] <= ram_wd;
        end
        r_ram_q     <= ram_mem[row_w.addr];
        r_ram_q_vld <= r_ram_vld[row_w.addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_in_data.func == FUNC_STEP) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (row_w.opcode == OP_LDA_MEM || row_w.opcode == OP_LDB_MEM) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and next register values
    always_comb begin
        o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
        n_pc       = r_pc;
        n_a        = r_a;
        n_b        = r_b;
        n_x        = r_x;
        n_flags    = r_flags;
        prog_we    = 1'b0;
        ram_we     = 1'b0;
        ram_wd     = r_x;
        ram_clear  = 1'b0;
        done       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_data.func)
                        FUNC_STEP: n_pc = r_pc + 4'd1;
                        FUNC_WRITE: begin
                            prog_we = 1'b1;
                            done    = 1'b1;
                        end
                        FUNC_RESTART: begin
                            n_pc      = PC_RESTART;
                            n_a       = '0;
                            n_b       = '0;
                            n_x       = '0;
                            n_flags   = '0;
                            ram_clear = 1'b1;
                            done      = 1'b1;
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            ST_FETCH: begin
                done = 1'b1;
                unique case (row_w.opcode)
                    OP_LDA_IMM: n_a = row_w.imm;
                    OP_LDB_IMM: n_b = row_w.imm;
                    OP_LDA_MEM, OP_LDB_MEM: done = 1'b0;
                    OP_MUL: begin
                        n_x     = mul_p[3:0];
                        n_flags = '{ovf: |mul_p[7:4], neg: 1'b0, zero: mul_p[3:0] == 4'd0};
                    end
                    OP_DIV: begin
                        if (r_b == 4'd0) begin
                            n_x     = '0;
                            n_flags = '{ovf: 1'b1, neg: 1'b0, zero: 1'b1};
                        end else begin
                            n_x     = div_q;
                            n_flags = '{ovf: 1'b0, neg: 1'b0, zero: div_q == 4'd0};
                        end
                    end
                    OP_ADD: begin
                        n_x     = add_s[3:0];
                        n_flags = '{ovf: add_s[4], neg: 1'b0, zero: add_s[3:0] == 4'd0};
                    end
                    OP_SUB: begin
                        // borrow means a negative raw difference
                        n_x     = sub_d[3:0];
                        n_flags = '{ovf: sub_d[4], neg: sub_d[4], zero: sub_d[3:0] == 4'd0};
                    end
                    OP_STX: ram_we = 1'b1;
                    OP_STA: begin
                        ram_we = 1'b1;
                        ram_wd = r_a;
                    end
                    OP_STB: begin
                        ram_we = 1'b1;
                        ram_wd = r_b;
                    end
                    OP_JMP: n_pc = row_w.addr;
                    OP_JZE: if (r_flags.zero) n_pc = row_w.addr;
                    OP_JOV: if (r_flags.ovf) n_pc = row_w.addr;
                    OP_JNE: if (r_flags.neg) n_pc = row_w.addr;
                    default: ;
                endcase
            end
            ST_LOAD: begin
                done = 1'b1;
                if (r_load_b) begin
                    n_b = ram_rd;
                end else begin
                    n_a = ram_rd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= PC_RESTART;
            r_a         <= '0;
            r_b         <= '0;
            r_x         <= '0;
            r_flags     <= '0;
            r_prog_vld  <= '0;
            r_ram_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_a     <= n_a;
            r_b     <= n_b;
            r_x     <= n_x;
            r_flags <= n_flags;
            if (prog_we) begin
                r_prog_vld[i_in_data.row] <= 1'b1;
            end
            if (ram_clear) begin
                r_ram_vld <= '0;
            end else if (ram_we) begin
                r_ram_vld[row_w.addr] <= 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) begin
            r_load_b <= (row_w.opcode == OP_LDB_MEM);
        end
        if (done) begin
            r_out <= '{row_done: n_pc, acc_a: n_a, acc_b: n_b, result_x: n_x,
                       zero_flag: n_flags.zero, negative_flag: n_flags.neg,
                       overflow_flag: n_flags.ovf};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> test/four_bit_cpu_step_unit_tb.sv
// Self-checking bench for the four-bit step unit: a directed program, then random
// program loads, step runs and restarts, checked word by word against a built-in machine model.
// Depends on fbcs_pkg and four_bit_cpu_step_unit.
module four_bit_cpu_step_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbcs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 700;
    localparam int DRAIN_CYCLES = 12;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    // words waiting to be sent, and machine states still to come back
    t_in_word  send_q[$];
    t_out_word state_q[$];

    // model of the machine
    t_prog_row  prog_rows [16];
    logic [3:0] ram_words [16];
    logic [3:0] cpu_pc;
    logic [3:0] cpu_a;
    logic [3:0] cpu_b;
    logic [3:0] cpu_x;
    t_flags     cpu_flags;

    int fail_count = 0;
    int cycle_count = 0;

    four_bit_cpu_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_machine();
        cpu_pc    = PC_RESTART;
        cpu_a     = '0;
        cpu_b     = '0;
        cpu_x     = '0;
        cpu_flags = '0;
        for (int i = 0; i < 16; i++) ram_words[i] = '0;
    endfunction

    function automatic void alu_update(int raw);
        cpu_x          = raw[3:0];
        cpu_flags.zero = (raw[3:0] == 4'd0);
        cpu_flags.neg  = (raw < 0);
        cpu_flags.ovf  = (raw > 15) || (raw < 0);
    endfunction

    // Apply one input word to the model and return the visible state afterwards
    function automatic t_out_word run_cpu_word(t_in_word w);
        t_prog_row pr;
        int        a;
        int        b;
        t_out_word r;
        case (t_func'(w.func))
            FUNC_STEP: begin
                cpu_pc = cpu_pc + 4'd1;
                pr = prog_rows[cpu_pc];
                a = int'(cpu_a);
                b = int'(cpu_b);
                case (t_opcode'(pr.opcode))
                    OP_LDA_IMM: cpu_a = pr.imm;
                    OP_LDA_MEM: cpu_a = ram_words[pr.addr];
                    OP_LDB_IMM: cpu_b = pr.imm;
                    OP_LDB_MEM: cpu_b = ram_words[pr.addr];
                    OP_MUL:     alu_update(a * b);
                    OP_DIV: begin
                        if (b == 0) begin
                            cpu_x     = '0;
                            cpu_flags = '{ovf: 1'b1, neg: 1'b0, zero: 1'b1};
                        end else begin
                            alu_update(a / b);
                        end
                    end
                    OP_ADD:     alu_update(a + b);
                    OP_SUB:     alu_update(a - b);
                    OP_STX:     ram_words[pr.addr] = cpu_x;
                    OP_STA:     ram_words[pr.addr] = cpu_a;
                    OP_STB:     ram_words[pr.addr] = cpu_b;
                    OP_JMP:     cpu_pc = pr.addr;
                    OP_JZE:     if (cpu_flags.zero) cpu_pc = pr.addr;
                    OP_JOV:     if (cpu_flags.ovf) cpu_pc = pr.addr;
                    OP_JNE:     if (cpu_flags.neg) cpu_pc = pr.addr;
                    default:    ;
                endcase
            end
            FUNC_WRITE:   prog_rows[w.row] = '{opcode: w.opcode, addr: w.addr, imm: w.imm};
            FUNC_RESTART: clear_machine();
            default:      ;
        endcase
        r.row_done      = cpu_pc;
        r.acc_a         = cpu_a;
        r.acc_b         = cpu_b;
        r.result_x      = cpu_x;
        r.zero_flag     = cpu_flags.zero;
        r.negative_flag = cpu_flags.neg;
        r.overflow_flag = cpu_flags.ovf;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_in_word random_word(t_func f);
        logic [31:0]                 rnd;
        logic [$bits(t_in_word)-1:0] bits;
        t_in_word                    w;
        rnd = $urandom;
        bits = rnd[$bits(t_in_word)-1:0];
        w = bits;
        w.func = f;
        return w;
    endfunction

    function automatic void queue_row(logic [3:0] row, t_opcode op, logic [3:0] addr,
                                      logic [3:0] imm);
        t_in_word w;
        w = random_word(FUNC_WRITE);
        w.row    = row;
        w.opcode = op;
        w.addr   = addr;
        w.imm    = imm;
        send_q.push_back(w);
    endfunction

    function automatic void queue_steps(int n);
        repeat (n) send_q.push_back(random_word(FUNC_STEP));
    endfunction

    // Driver: hold a word until taken, then idle for the drawn number of cycles
    int  in_idle = 0;
    bit  in_quiet = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) state_q.push_back(run_cpu_word(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (in_idle > 0) begin
                    in_idle--;
                    i_in_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    i_in_data  <= send_q.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
                    in_idle = in_quiet ? 0 : $urandom_range(0, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result word, then stall for the drawn number of cycles
    int  out_hold = 0;
    bit  out_quiet = 1'b0;
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (state_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = state_q.pop_front();
                    check_field("row_done", want.row_done, o_out_data.row_done);
                    check_field("acc_a", want.acc_a, o_out_data.acc_a);
                    check_field("acc_b", want.acc_b, o_out_data.acc_b);
                    check_field("result_x", want.result_x, o_out_data.result_x);
                    check_field("zero_flag", want.zero_flag, o_out_data.zero_flag);
                    check_field("negative_flag", want.negative_flag,
                                o_out_data.negative_flag);
                    check_field("overflow_flag", want.overflow_flag,
                                o_out_data.overflow_flag);
                end
                if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
                out_hold = out_quiet ? 0 : $urandom_range(0, 16);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n;
        for (int i = 0; i < 16; i++) prog_rows[i] = '0;
        clear_machine();

        // Directed program: divide by zero, taken jumps, negative difference,
        // store of B followed by a jump that must not be skipped, overflowing add
        queue_row(4'd0,  OP_LDA_IMM, 4'h0, 4'h3);
        queue_row(4'd1,  OP_LDB_IMM, 4'hA, 4'h0);
        queue_row(4'd2,  OP_DIV,     4'h5, 4'hF);
        queue_row(4'd3,  OP_JZE,     4'h4, 4'h0);
        queue_row(4'd4,  OP_STA,     4'h1, 4'h0);
        queue_row(4'd5,  OP_LDB_IMM, 4'h0, 4'hF);
        queue_row(4'd6,  OP_SUB,     4'h0, 4'h0);
        queue_row(4'd7,  OP_STB,     4'hF, 4'h0);
        queue_row(4'd8,  OP_JNE,     4'h9, 4'h0);
        queue_row(4'd9,  OP_NOP,     4'hF, 4'hF);
        queue_row(4'd10, OP_LDA_MEM, 4'hF, 4'h0);
        queue_row(4'd11, OP_MUL,     4'h0, 4'h0);
        queue_row(4'd12, OP_STX,     4'h0, 4'h0);
        queue_row(4'd13, OP_LDB_MEM, 4'h0, 4'h0);
        queue_row(4'd14, OP_ADD,     4'h0, 4'h0);
        queue_row(4'd15, OP_JOV,     4'h8, 4'h0);
        queue_steps(15);
        send_q.push_back(random_word(FUNC_SPARE));
        send_q.push_back(random_word(FUNC_RESTART));
        queue_row(4'd0,  OP_JMP,     4'h3, 4'h0);
        queue_steps(3);

        // Random: load a few rows, then run them; restart now and then
        while (send_q.size() < RANDOM_WORDS + 40) begin
            if ($urandom_range(0, 5) == 0) send_q.push_back(random_word(FUNC_RESTART));
            repeat ($urandom_range(1, 6)) send_q.push_back(random_word(FUNC_WRITE));
            if ($urandom_range(0, 9) == 0) send_q.push_back(random_word(FUNC_SPARE));
            n = $urandom_range(4, 40);
            queue_steps(n);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the rising edge so the driver and monitor have settled
        do @(negedge i_clk);
        while (send_q.size() > 0 || i_in_valid || state_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
